// ===== hdl/flt_pkg.sv =====
package flt_pkg;

    localparam int TAPS_DEFAULT = 64;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W = 6;
    localparam int CFG_W = 7;
    localparam int PROD_W = 2 * SAMPLE_W;

    localparam logic [CFG_W-1:0] TAPS_RESET = 7'd64;

    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_COEF = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_q15;

    typedef struct packed {
        logic             shift_in;
        logic             rotate;
        logic             coef_we;
        logic [IDX_W-1:0] coef_idx;
        t_q15             coef_val;
    } t_cell_ctl;

endpackage

// ===== hdl/flt_if.sv =====
interface flt_in_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic signed [flt_pkg::SAMPLE_W-1:0] sample_in;
    logic [flt_pkg::IDX_W-1:0]          coef_index;
    logic signed [flt_pkg::SAMPLE_W-1:0] coef_value;

    modport source (output valid, func, sample_in, coef_index, coef_value, input ready);
    modport sink (input valid, func, sample_in, coef_index, coef_value, output ready);
endinterface

interface flt_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [flt_pkg::SAMPLE_W-1:0] sample_out;
    logic                               clipped;

    modport source (output valid, sample_out, clipped, input ready);
    modport sink (input valid, sample_out, clipped, output ready);
endinterface

// ===== hdl/fir_filter_loadable_taps.sv =====
// FIR filter with loadable coefficients, Q1.15 in and out. The taps sit in a ring of
// TAPS cells, each holding one past sample and one coefficient. A coefficient write item
// gives no result and leaves the block ready. A sample item shifts the history in, then
// rotates the ring TAPS times past one shared multiply-accumulate unit, which sums the
// first r_taps products. No new item is taken until DRAIN and DONE lead back to idle.
// A finished result waits in the output register while the next item is taken. The
// wide sum is rounded half up to Q1.15 and saturated, with clipped set if it saturates.
module fir_filter_loadable_taps #(
    parameter int TAPS = flt_pkg::TAPS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [flt_pkg::CFG_W-1:0]  i_cfg_data,
    flt_in_if.sink                     i_in,
    flt_out_if.source                  o_out
);

    localparam int SW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int KW = ((SW > flt_pkg::CFG_W) ? SW : flt_pkg::CFG_W) + 1;
    localparam int AW = flt_pkg::PROD_W + SW + 1;
    localparam int QW = AW - 15;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic signed [QW-1:0] QMAX = QW'(32767);
    localparam logic signed [QW-1:0] QMIN = QW'(-32768);

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    logic [SW-1:0]                r_step;
    logic [SW-1:0]                n_step;
    logic [flt_pkg::CFG_W-1:0]    r_taps;
    logic                         r_out_valid;
    flt_pkg::t_q15                r_out_sample;
    logic                         r_out_clip;

    logic                         w_accept;
    logic                         w_load;
    logic                         w_take;
    flt_pkg::t_cell_ctl           w_ctl;
    flt_pkg::t_q15                w_hist [TAPS];
    flt_pkg::t_q15                w_coef [TAPS];
    logic signed [AW-1:0]         w_acc;
    logic signed [AW-1:0]         w_rnd;
    logic signed [QW-1:0]         w_q;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept = i_in.valid && i_in.ready;

    assign w_ctl.shift_in = w_accept && (i_in.func == flt_pkg::FUNC_FILTER);
    assign w_ctl.rotate = (r_state == ST_RUN);
    assign w_ctl.coef_we = w_accept && (i_in.func == flt_pkg::FUNC_COEF);
    assign w_ctl.coef_idx = i_in.coef_index;
    assign w_ctl.coef_val = i_in.coef_value;

    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        flt_pkg::t_q15 w_prev;
        if (g == 0) begin : g_head
            assign w_prev = i_in.sample_in;
        end else begin : g_body
            assign w_prev = w_hist[g-1];
        end
        flt_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_hist_prev (w_prev),
            .i_hist_next (w_hist[(g+1) % TAPS]),
            .i_coef_next (w_coef[(g+1) % TAPS]),
            .o_hist      (w_hist[g]),
            .o_coef      (w_coef[g])
        );
    end

    assign w_take = (r_state == ST_RUN) &&
                    ({{(KW-SW){1'b0}}, r_step} < {{(KW-flt_pkg::CFG_W){1'b0}}, r_taps});

    flt_mac #(
        .AW(AW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_ctl.shift_in),
        .i_take  (w_take),
        .i_h     (w_coef[0]),
        .i_x     (w_hist[0]),
        .o_acc   (w_acc)
    );

    assign w_rnd = w_acc + {{(AW-15){1'b0}}, 15'h4000};
    assign w_q = w_rnd[AW-1:15];

    assign w_load = (r_state == ST_DONE) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        n_step = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (w_ctl.shift_in) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == SW'(TAPS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step <= '0;
            r_taps <= flt_pkg::TAPS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step <= n_step;
            if (i_cfg_we) begin
                r_taps <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_q > QMAX) begin
                r_out_sample <= 16'sh7fff;
                r_out_clip <= 1'b1;
            end else if (w_q < QMIN) begin
                r_out_sample <= 16'sh8000;
                r_out_clip <= 1'b1;
            end else begin
                r_out_sample <= w_q[flt_pkg::SAMPLE_W-1:0];
                r_out_clip <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.clipped = r_out_clip;

endmodule

// ===== hdl/flt_cell.sv =====
module flt_cell #(
    parameter int IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  flt_pkg::t_cell_ctl  i_ctl,
    input  flt_pkg::t_q15       i_hist_prev,
    input  flt_pkg::t_q15       i_hist_next,
    input  flt_pkg::t_q15       i_coef_next,
    output flt_pkg::t_q15       o_hist,
    output flt_pkg::t_q15       o_coef
);

    flt_pkg::t_q15    r_hist;
    flt_pkg::t_q15    r_coef;
    logic             w_sel;

    assign w_sel = ({{(32-flt_pkg::IDX_W){1'b0}}, i_ctl.coef_idx} == 32'(IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_coef <= '0;
        end else begin
            if (i_ctl.shift_in) begin
                r_hist <= i_hist_prev;
            end else if (i_ctl.rotate) begin
                r_hist <= i_hist_next;
            end
            if (i_ctl.rotate) begin
                r_coef <= i_coef_next;
            end else if (i_ctl.coef_we && w_sel) begin
                r_coef <= i_ctl.coef_val;
            end
        end
    end

    assign o_hist = r_hist;
    assign o_coef = r_coef;

endmodule

// ===== hdl/flt_mac.sv =====
module flt_mac #(
    parameter int AW = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_take,
    input  flt_pkg::t_q15        i_h,
    input  flt_pkg::t_q15        i_x,
    output logic signed [AW-1:0] o_acc
);

    logic signed [flt_pkg::PROD_W-1:0] r_prod;
    logic                              r_pvld;
    logic signed [AW-1:0]              r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_h * i_x;
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + {{(AW-flt_pkg::PROD_W){r_prod[flt_pkg::PROD_W-1]}}, r_prod};
        end
    end

    assign o_acc = r_acc;

endmodule
